/* rtl/core/scmd_pkg.sv */
package scmd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned NAME_W   = 2 * BYTE_W;
    localparam int unsigned NAMES_PER_WORD = 4;
    localparam int unsigned NAME_SLOTS     = 8;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned IN_USE_W       = 4;

    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

    localparam logic [LEN_W-1:0] MIN_NAME_LEN = 8'd2;
    localparam logic [LEN_W-1:0] LEN_MAX      = 8'hFF;

    localparam logic [STATUS_W-1:0] STATUS_MATCH     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NAMES_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAMES_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAMES_USE  = 2'd2;

    typedef enum logic [1:0] {
        TERM_NONE = 2'd0,
        TERM_CR   = 2'd1,
        TERM_LF   = 2'd2
    } t_term;

    // Line contents as seen at the terminator that closes it.
    typedef struct packed {
        logic [BYTE_W-1:0] first_char;
        logic [BYTE_W-1:0] second_char;
        logic [LEN_W-1:0]  eff_len;
    } t_line_info;

endpackage

/* rtl/core/scmd_framer.sv */
module scmd_framer #(
    parameter int unsigned LINE_CAPACITY = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_consume,
    input  logic [scmd_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_emit,
    output scmd_pkg::t_line_info        o_line
);
    import scmd_pkg::*;

    localparam int unsigned CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CAPACITY - 1);

    t_term             r_prev,   n_prev;
    logic [BYTE_W-1:0] r_first,  n_first;
    logic [BYTE_W-1:0] r_second, n_second;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [LEN_W-1:0]  r_eff,    n_eff;
    logic              r_zero,   n_zero;

    logic  is_term;
    t_term code;

    assign is_term = (i_byte == CHAR_CR) || (i_byte == CHAR_LF);
    assign code    = (i_byte == CHAR_CR) ? TERM_CR : TERM_LF;
    assign o_emit  = i_valid && is_term && ((r_prev == TERM_NONE) || (r_prev == code));

    assign o_line.first_char  = r_first;
    assign o_line.second_char = r_second;
    assign o_line.eff_len     = r_eff;

    always_comb begin
        n_prev   = r_prev;
        n_first  = r_first;
        n_second = r_second;
        n_count  = r_count;
        n_eff    = r_eff;
        n_zero   = r_zero;
        if (i_consume) begin
            n_prev = TERM_NONE;
            if (is_term) begin
                if (o_emit) begin
                    n_prev   = code;
                    n_first  = '0;
                    n_second = '0;
                    n_count  = '0;
                    n_eff    = '0;
                    n_zero   = 1'b0;
                end
            end else if (r_count < CNT_LIMIT) begin
                n_count = r_count + 1'b1;
                if (!r_zero) begin
                    if (i_byte == CHAR_NUL) begin
                        n_zero = 1'b1;
                    end else begin
                        if (r_eff == '0) begin
                            n_first = i_byte;
                        end else if (r_eff == LEN_W'(1)) begin
                            n_second = i_byte;
                        end
                        // saturate; reported length tops out at 255
                        if (r_eff != LEN_MAX) begin
                            n_eff = r_eff + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= TERM_NONE;
            r_first  <= '0;
            r_second <= '0;
            r_count  <= '0;
            r_eff    <= '0;
            r_zero   <= 1'b0;
        end else begin
            r_prev   <= n_prev;
            r_first  <= n_first;
            r_second <= n_second;
            r_count  <= n_count;
            r_eff    <= n_eff;
            r_zero   <= n_zero;
        end
    end

endmodule

/* rtl/core/scmd_match.sv */
module scmd_match #(
    parameter int unsigned MAX_COMMANDS = 8
) (
    input  scmd_pkg::t_line_info                           i_line,
    input  logic [scmd_pkg::CFG_DATA_W-1:0]                i_names_low,
    input  logic [scmd_pkg::CFG_DATA_W-1:0]                i_names_high,
    input  logic [scmd_pkg::IN_USE_W-1:0]                  i_names_in_use,
    output logic [scmd_pkg::STATUS_W-1:0]                  o_status,
    output logic [scmd_pkg::INDEX_W-1:0]                   o_cmd_index,
    output logic [scmd_pkg::LEN_W-1:0]                     o_text_length
);
    import scmd_pkg::*;

    logic [2*CFG_DATA_W-1:0] names;
    logic [NAME_W-1:0]       key;
    logic                    hit;
    logic [INDEX_W-1:0]      hit_idx;

    assign names = {i_names_high, i_names_low};
    assign key   = {i_line.second_char, i_line.first_char};

    // Scan from the top down so the lowest matching index wins.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_COMMANDS - 1; i >= 0; i--) begin
            if ((IN_USE_W'(i) < i_names_in_use) && (names[i*NAME_W +: NAME_W] == key)) begin
                hit     = 1'b1;
                hit_idx = INDEX_W'(i);
            end
        end
    end

    always_comb begin
        o_text_length = i_line.eff_len;
        o_cmd_index   = '0;
        if (i_line.eff_len < MIN_NAME_LEN) begin
            o_status = STATUS_TOO_SHORT;
        end else if (hit) begin
            o_status    = STATUS_MATCH;
            o_cmd_index = hit_idx;
        end else begin
            o_status = STATUS_NO_MATCH;
        end
    end

endmodule

/* rtl/core/serial_command_line_matcher.sv */
// Serial command line matcher.
// Input channel: one received character per request on i_data_byte, qualified
// by i_in_valid and held off by o_in_stall. CR or LF closes a line; the second
// half of a CR LF or LF CR pair is swallowed, and a repeated identical
// terminator closes an empty line.
// Output channel: one request per closed line on o_status, o_cmd_index and
// o_text_length, qualified by o_out_valid and held off by i_out_stall.
// Status is matched (with the lowest matching name index), no match, or too
// short when the line has fewer than two characters before any zero byte.
// Configuration: i_cfg_index / i_cfg_data written when i_cfg_valid is high;
// o_cfg_ready is always high. Write only while the block is idle.
// Timing: a character is taken into the input register and is framed and
// compared in the following cycle; a closing terminator's result is loaded
// into the result register as the terminator retires from the input register,
// and o_out_valid rises with it. One character per cycle is sustained unless
// a closing terminator is held. While the receiver stalls, other characters
// keep flowing; a terminator that closes a line waits in the input register,
// with o_in_stall high, until the result register frees up.
// Reset (synchronous, active low) clears the line state, both stages and the
// name registers.
module serial_command_line_matcher #(
    parameter int unsigned LINE_CAPACITY = 256,
    parameter int unsigned MAX_COMMANDS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [scmd_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [scmd_pkg::STATUS_W-1:0]   o_status,
    output logic [scmd_pkg::INDEX_W-1:0]    o_cmd_index,
    output logic [scmd_pkg::LEN_W-1:0]      o_text_length,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scmd_pkg::*;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_names_low;
    logic [CFG_DATA_W-1:0] r_names_high;
    logic [IN_USE_W-1:0]   r_names_in_use;

    // Input stage.
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;

    // Result stage.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [INDEX_W-1:0]  r_cmd_index;
    logic [LEN_W-1:0]    r_text_length;

    logic                in_accept;
    logic                out_free;
    logic                s1_emit;
    logic                s1_consume;
    t_line_info          line;
    logic [STATUS_W-1:0] m_status;
    logic [INDEX_W-1:0]  m_cmd_index;
    logic [LEN_W-1:0]    m_text_length;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_names_low    <= '0;
            r_names_high   <= '0;
            r_names_in_use <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NAMES_LOW:  r_names_low    <= i_cfg_data;
                CFG_NAMES_HIGH: r_names_high   <= i_cfg_data;
                CFG_NAMES_USE:  r_names_in_use <= i_cfg_data[IN_USE_W-1:0];
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    // A held character retires unless it closes a line and the result
    // register is still occupied by an untaken request.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_consume = r_s1_valid && (!s1_emit || out_free);
    assign o_in_stall = r_s1_valid && !s1_consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte <= i_data_byte;
        end
    end

    scmd_framer #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .i_consume (s1_consume),
        .i_byte    (r_s1_byte),
        .o_emit    (s1_emit),
        .o_line    (line)
    );

    scmd_match #(
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_match (
        .i_line         (line),
        .i_names_low    (r_names_low),
        .i_names_high   (r_names_high),
        .i_names_in_use (r_names_in_use),
        .o_status       (m_status),
        .o_cmd_index    (m_cmd_index),
        .o_text_length  (m_text_length)
    );

    // Load a result when a line closes; drop valid once the request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_consume && s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_consume && s1_emit) begin
            r_status      <= m_status;
            r_cmd_index   <= m_cmd_index;
            r_text_length <= m_text_length;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_cmd_index   = r_cmd_index;
    assign o_text_length = r_text_length;

endmodule
